>>> hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions used by the checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Assertion disabled while the active-low reset is asserted.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

>>> hdl/cic_pkg.sv
// ---------------------------------------------------------------------------
// Compressor interlock controller package
// Shared types and constants for the pass logic and the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cic_pkg;

  localparam int unsigned DELAY_W = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned TEMP_W  = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [DELAY_W-1:0] DELAY_RST   = 16'd3000;
  localparam logic signed [TEMP_W-1:0] CUT_IN_RST  = 8'sd4;
  localparam logic signed [TEMP_W-1:0] CUT_OUT_RST = 8'sd1;

  typedef logic signed [TEMP_W-1:0] temp_t;

  // Command codes carried with each beat; the unused code means no command.
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_START = 2'd1,
    KIND_STOP  = 2'd2
  } kind_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_DELAY = 2'd0,
    CFG_CUT_IN      = 2'd1,
    CFG_CUT_OUT     = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_SHUTDOWN = 3'd1,
    PH_START    = 3'd2,
    PH_WAIT     = 3'd3,
    PH_RUN      = 3'd4,
    PH_ENGCUT   = 3'd5
  } phase_t;

  typedef struct packed {
    logic [DELAY_W-1:0] start_delay_ms;
    temp_t              cut_in_temp;
    temp_t              cut_out_temp;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [TIME_W-1:0] now_ms;
    logic              single_switch;
    logic              dual_switch;
    logic              engine_permit;
    temp_t             evaporator_temp;
  } item_t;

  typedef struct packed {
    phase_t            phase;
    logic [TIME_W-1:0] timer_start;
    logic              await_cut_in;
    logic              clutch;
    logic              idle_up;
    logic              fan_request;
    logic              active;
    logic              last_single;
  } state_t;

  typedef struct packed {
    logic   clutch_on;
    logic   idle_up;
    logic   fan_request;
    logic   compressor_active;
    logic   report_compressor;
    logic   report_fan;
    phase_t phase;
  } result_t;

endpackage

>>> hdl/compressor_interlock_controller_top.sv
// ---------------------------------------------------------------------------
// Compressor interlock controller
// Input register, one combinational control pass, result register.
// ---------------------------------------------------------------------------
// A beat moves from the input register to the result register.
// One beat per cycle unless stalled; the control state feeds back to the pass.
// Reset (synchronous, rst_n low): pipeline empty, phase idle, all drives off,
// timer zero, delay 3000 ms, cut-in 4, cut-out 1.
// The configuration port is always ready.
`timescale 1ns / 1ps

module compressor_interlock_controller_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_kind,
  input  logic [cic_pkg::TIME_W-1:0]     in_now_ms,
  input  logic                           in_single_switch,
  input  logic                           in_dual_switch,
  input  logic                           in_engine_permit,
  input  logic signed [cic_pkg::TEMP_W-1:0] in_evaporator_temp,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_clutch_on,
  output logic                           out_idle_up,
  output logic                           out_fan_request,
  output logic                           out_compressor_active,
  output logic                           out_report_compressor,
  output logic                           out_report_fan,
  output logic [2:0]                     out_phase,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cic_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cic_pkg::DELAY_W-1:0]    cfg_wdata
);
  import cic_pkg::*;

  cfg_t    cfg_r;
  cfg_t    cfg_nxt;
  item_t   item_r;
  logic    s1_vld_r;
  state_t  state_r;
  state_t  state_nxt;
  result_t res_nxt;
  result_t res_r;
  logic    out_vld_r;
  logic    advance;
  logic    in_take;

  // Configuration writes.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_START_DELAY: cfg_nxt.start_delay_ms = cfg_wdata;
        CFG_CUT_IN:      cfg_nxt.cut_in_temp    = temp_t'(cfg_wdata[TEMP_W-1:0]);
        CFG_CUT_OUT:     cfg_nxt.cut_out_temp   = temp_t'(cfg_wdata[TEMP_W-1:0]);
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_delay_ms <= DELAY_RST;
      cfg_r.cut_in_temp    <= CUT_IN_RST;
      cfg_r.cut_out_temp   <= CUT_OUT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Pipeline flow: the pass runs when the result register can take a beat.
  assign advance  = !out_vld_r || !out_stall;
  assign in_stall = s1_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (advance || !s1_vld_r) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.kind            <= in_kind;
      item_r.now_ms          <= in_now_ms;
      item_r.single_switch   <= in_single_switch;
      item_r.dual_switch     <= in_dual_switch;
      item_r.engine_permit   <= in_engine_permit;
      item_r.evaporator_temp <= in_evaporator_temp;
    end
  end

  // Control pass.
  cic_step u_step (
    .cfg  (cfg_r),
    .item (item_r),
    .cur  (state_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  // Control state commits when the pass result moves into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase        <= PH_IDLE;
      state_r.timer_start  <= '0;
      state_r.await_cut_in <= 1'b0;
      state_r.clutch       <= 1'b0;
      state_r.idle_up      <= 1'b0;
      state_r.fan_request  <= 1'b0;
      state_r.active       <= 1'b0;
      state_r.last_single  <= 1'b0;
    end else if (s1_vld_r && advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r && advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid             = out_vld_r;
  assign out_clutch_on         = res_r.clutch_on;
  assign out_idle_up           = res_r.idle_up;
  assign out_fan_request       = res_r.fan_request;
  assign out_compressor_active = res_r.compressor_active;
  assign out_report_compressor = res_r.report_compressor;
  assign out_report_fan        = res_r.report_fan;
  assign out_phase             = res_r.phase;

endmodule

>>> hdl/cic_step.sv
// ---------------------------------------------------------------------------
// Compressor interlock pass logic
// Combinational control pass: command, switch change detect, phase step.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cic_step (
  input  cic_pkg::cfg_t    cfg,
  input  cic_pkg::item_t   item,
  input  cic_pkg::state_t  cur,
  output cic_pkg::state_t  nxt,
  output cic_pkg::result_t res
);
  import cic_pkg::*;

  phase_t            ph_cmd;
  phase_t            phase_nxt;
  logic [TIME_W-1:0] elapsed;
  logic              delay_done;
  logic              sw_high;
  logic              rep_comp;
  logic              rep_fan;

  // A command overrides the stored phase before the step runs.
  always_comb begin
    unique case (kind_t'(item.kind))
      KIND_START: ph_cmd = PH_START;
      KIND_STOP:  ph_cmd = PH_SHUTDOWN;
      default:    ph_cmd = cur.phase;
    endcase
  end

  // Elapsed time wraps with the timestamp.
  assign elapsed    = item.now_ms - cur.timer_start;
  assign delay_done = elapsed >= {{(TIME_W-DELAY_W){1'b0}}, cfg.start_delay_ms};
  assign sw_high    = item.dual_switch | item.single_switch;

  // Next phase.
  always_comb begin
    unique case (ph_cmd)
      PH_SHUTDOWN: phase_nxt = PH_IDLE;
      PH_START:    phase_nxt = PH_WAIT;
      PH_WAIT:     phase_nxt = delay_done ? PH_RUN : PH_WAIT;
      PH_RUN: begin
        if (sw_high) begin
          phase_nxt = PH_SHUTDOWN;
        end else if (!item.engine_permit) begin
          phase_nxt = PH_ENGCUT;
        end else begin
          phase_nxt = PH_RUN;
        end
      end
      PH_ENGCUT:   phase_nxt = PH_WAIT;
      default:     phase_nxt = ph_cmd;
    endcase
  end

  // Drive levels, timer and hysteresis state.
  always_comb begin
    nxt             = cur;
    nxt.phase       = phase_nxt;
    nxt.last_single = item.single_switch;
    rep_comp        = 1'b0;
    rep_fan         = item.single_switch != cur.last_single;
    unique case (ph_cmd)
      PH_SHUTDOWN: begin
        nxt.idle_up     = 1'b0;
        nxt.clutch      = 1'b0;
        nxt.fan_request = 1'b0;
        nxt.active      = 1'b0;
        rep_comp        = 1'b1;
        rep_fan         = 1'b1;
      end
      PH_START: begin
        nxt.timer_start = item.now_ms;
        nxt.idle_up     = 1'b1;
        nxt.fan_request = 1'b1;
        nxt.active      = 1'b1;
        rep_comp        = 1'b1;
        rep_fan         = 1'b1;
      end
      PH_WAIT: begin
        if (delay_done) begin
          nxt.await_cut_in = 1'b1;
        end
      end
      PH_RUN: begin
        // Clutch hysteresis only while switches are low and permit is given.
        if (!sw_high && item.engine_permit) begin
          if (cur.await_cut_in) begin
            if (item.evaporator_temp >= cfg.cut_in_temp) begin
              nxt.await_cut_in = 1'b0;
              nxt.clutch       = 1'b1;
            end
          end else if (item.evaporator_temp <= cfg.cut_out_temp) begin
            nxt.await_cut_in = 1'b1;
            nxt.clutch       = 1'b0;
          end
        end
      end
      PH_ENGCUT: begin
        nxt.clutch      = 1'b0;
        nxt.timer_start = item.now_ms;
      end
      default: begin
        nxt.phase = phase_nxt;
      end
    endcase
  end

  // Result of the pass.
  always_comb begin
    res.clutch_on         = nxt.clutch;
    res.idle_up           = nxt.idle_up;
    res.fan_request       = nxt.fan_request;
    res.compressor_active = nxt.active;
    res.report_compressor = rep_comp;
    res.report_fan        = rep_fan;
    res.phase             = nxt.phase;
  end

endmodule

>>> hdl/cic_checker.sv
// ---------------------------------------------------------------------------
// Compressor interlock port checker
// Port-level assertions on the result channel, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cic_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_clutch_on,
  input logic       out_idle_up,
  input logic       out_compressor_active,
  input logic       out_report_compressor,
  input logic [2:0] out_phase
);
  import cic_pkg::*;

  // The result channel is empty right after reset.
  `ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_valid, "result beat right after reset")

  // A stalled result beat holds.
  `ASSERT_RST(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_phase) && $stable(out_clutch_on), "stalled result beat changed")

  // A start or shutdown step always ends in wait or idle.
  `ASSERT_RST(a_report_phase, clk, rst_n, out_valid && out_report_compressor |-> out_phase == PH_IDLE || out_phase == PH_WAIT, "report with unexpected phase")

  // The clutch is only driven while the system is active with idle-up raised.
  `ASSERT_RST(a_clutch_active, clk, rst_n, out_valid && out_clutch_on |-> out_compressor_active && out_idle_up, "clutch on while inactive")

endmodule

bind compressor_interlock_controller_top cic_checker u_cic_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_valid             (out_valid),
  .out_stall             (out_stall),
  .out_clutch_on         (out_clutch_on),
  .out_idle_up           (out_idle_up),
  .out_compressor_active (out_compressor_active),
  .out_report_compressor (out_report_compressor),
  .out_phase             (out_phase)
);

>>> tb/sv/tb_compressor_interlock_controller_top.sv
// ---------------------------------------------------------------------------
// Compressor interlock controller testbench
// Runs a table of hand-picked control passes, then four blocks of random
// passes under different delay and threshold settings. Both channels idle
// and stall at random. Every result beat is checked against a result typed in
// by hand or against a cycle-free model of the pass logic kept in this file.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_compressor_interlock_controller_top;
  import cic_pkg::*;

  // The command code that has no meaning acts as no command.
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam temp_t TEMP_MIN = 8'sh80;
  localparam temp_t TEMP_MAX = 8'sh7F;
  localparam int ROWS = 25;

  typedef struct packed {
    item_t   beat;
    logic    fixed;
    result_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [1:0]               in_kind = KIND_NONE;
  logic [TIME_W-1:0]        in_now_ms = '0;
  logic                     in_single_switch = 1'b0;
  logic                     in_dual_switch = 1'b0;
  logic                     in_engine_permit = 1'b0;
  logic signed [TEMP_W-1:0] in_evaporator_temp = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     out_clutch_on;
  logic                     out_idle_up;
  logic                     out_fan_request;
  logic                     out_compressor_active;
  logic                     out_report_compressor;
  logic                     out_report_fan;
  logic [2:0]               out_phase;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = CFG_START_DELAY;
  logic [DELAY_W-1:0]       cfg_wdata = '0;

  // Model copy of the configuration registers.
  logic [DELAY_W-1:0] cfg_delay = DELAY_RST;
  temp_t              cfg_cut_in = CUT_IN_RST;
  temp_t              cfg_cut_out = CUT_OUT_RST;

  // Model copy of the control state.
  phase_t            st_phase = PH_IDLE;
  logic [TIME_W-1:0] st_timer = '0;
  logic              st_await = 1'b0;
  logic              st_clutch = 1'b0;
  logic              st_idle_up = 1'b0;
  logic              st_fan = 1'b0;
  logic              st_active = 1'b0;
  logic              st_last_single = 1'b0;

  result_t           awaited_drive[$];
  result_t           head_drive;
  logic [TIME_W-1:0] sim_now = 32'hFFFF_F000;
  bit                in_calm = 1'b0;
  bit                out_calm = 1'b0;
  int                sent_beats = 0;
  int                fails = 0;

  // Hand-picked passes; rows with fixed set carry a result typed in by hand.
  dir_row_t directed_rows [ROWS] = '{
    '{'{KIND_NONE, 32'd0, 1'b0, 1'b0, 1'b1, 8'sd0}, 1'b1,
      '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PH_IDLE}},
    '{'{KIND_UNUSED, 32'd50, 1'b1, 1'b0, 1'b1, 8'sd0}, 1'b1,
      '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, PH_IDLE}},
    '{'{KIND_START, 32'd100, 1'b0, 1'b0, 1'b1, TEMP_MAX}, 1'b1,
      '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, PH_WAIT}},
    '{'{KIND_NONE, 32'd3099, 1'b0, 1'b0, 1'b1, TEMP_MAX}, 1'b1,
      '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, PH_WAIT}},
    '{'{KIND_NONE, 32'd3100, 1'b0, 1'b0, 1'b1, TEMP_MAX}, 1'b1,
      '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, PH_RUN}},
    '{'{KIND_NONE, 32'd3200, 1'b0, 1'b0, 1'b1, 8'sd3}, 1'b0, '0},
    '{'{KIND_NONE, 32'd3300, 1'b0, 1'b0, 1'b1, 8'sd4}, 1'b1,
      '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, PH_RUN}},
    '{'{KIND_NONE, 32'd3400, 1'b0, 1'b0, 1'b1, 8'sd2}, 1'b0, '0},
    '{'{KIND_NONE, 32'd3500, 1'b0, 1'b0, 1'b1, 8'sd1}, 1'b0, '0},
    '{'{KIND_NONE, 32'd3600, 1'b0, 1'b0, 1'b1, TEMP_MIN}, 1'b0, '0},
    '{'{KIND_NONE, 32'd3700, 1'b0, 1'b0, 1'b1, TEMP_MAX}, 1'b0, '0},
    '{'{KIND_NONE, 32'hFFFF_FE00, 1'b0, 1'b0, 1'b0, 8'sd20}, 1'b0, '0},
    '{'{KIND_NONE, 32'hFFFF_FF00, 1'b0, 1'b0, 1'b0, 8'sd20}, 1'b0, '0},
    '{'{KIND_NONE, 32'h0000_0AB7, 1'b0, 1'b0, 1'b1, 8'sd20}, 1'b0, '0},
    '{'{KIND_NONE, 32'h0000_0AB8, 1'b0, 1'b0, 1'b1, 8'sd20}, 1'b0, '0},
    '{'{KIND_NONE, 32'h0000_0B00, 1'b0, 1'b0, 1'b1, TEMP_MIN}, 1'b0, '0},
    '{'{KIND_NONE, 32'h0000_0C00, 1'b0, 1'b0, 1'b1, 8'sd10}, 1'b0, '0},
    '{'{KIND_NONE, 32'h0000_0D00, 1'b0, 1'b1, 1'b1, 8'sd10}, 1'b0, '0},
    '{'{KIND_NONE, 32'h0000_0E00, 1'b0, 1'b0, 1'b1, 8'sd10}, 1'b1,
      '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, PH_IDLE}},
    '{'{KIND_START, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, TEMP_MIN}, 1'b0, '0},
    '{'{KIND_STOP, 32'h0000_0005, 1'b1, 1'b0, 1'b1, 8'sd0}, 1'b1,
      '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, PH_IDLE}},
    '{'{KIND_START, 32'h5555_5555, 1'b1, 1'b0, 1'b1, 8'sd0}, 1'b0, '0},
    '{'{KIND_NONE, 32'hAAAA_AAAA, 1'b1, 1'b0, 1'b1, 8'sd0}, 1'b0, '0},
    '{'{KIND_NONE, 32'hAAAA_AAAB, 1'b1, 1'b0, 1'b0, 8'sd0}, 1'b0, '0},
    '{'{KIND_UNUSED, 32'hAAAA_AAAC, 1'b0, 1'b0, 1'b1, 8'sd0}, 1'b0, '0}
  };

  compressor_interlock_controller_top dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_kind               (in_kind),
    .in_now_ms             (in_now_ms),
    .in_single_switch      (in_single_switch),
    .in_dual_switch        (in_dual_switch),
    .in_engine_permit      (in_engine_permit),
    .in_evaporator_temp    (in_evaporator_temp),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_clutch_on         (out_clutch_on),
    .out_idle_up           (out_idle_up),
    .out_fan_request       (out_fan_request),
    .out_compressor_active (out_compressor_active),
    .out_report_compressor (out_report_compressor),
    .out_report_fan        (out_report_fan),
    .out_phase             (out_phase),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // One control pass: command, switch edge, then one step of the phase.
  function automatic result_t run_control_pass(input item_t b);
    result_t           r;
    logic [TIME_W-1:0] elapsed;
    logic              rep_comp;
    logic              rep_fan;
    rep_comp = 1'b0;
    rep_fan = 1'b0;
    if (b.kind == KIND_START) st_phase = PH_START;
    else if (b.kind == KIND_STOP) st_phase = PH_SHUTDOWN;
    if (b.single_switch != st_last_single) begin
      st_last_single = b.single_switch;
      rep_fan = 1'b1;
    end
    case (st_phase)
      PH_SHUTDOWN: begin
        st_idle_up = 1'b0;
        st_clutch = 1'b0;
        st_fan = 1'b0;
        st_active = 1'b0;
        st_phase = PH_IDLE;
        rep_comp = 1'b1;
        rep_fan = 1'b1;
      end
      PH_START: begin
        st_timer = b.now_ms;
        st_idle_up = 1'b1;
        st_fan = 1'b1;
        st_active = 1'b1;
        st_phase = PH_WAIT;
        rep_comp = 1'b1;
        rep_fan = 1'b1;
      end
      PH_WAIT: begin
        elapsed = b.now_ms - st_timer;
        if (elapsed >= {16'd0, cfg_delay}) begin
          st_await = 1'b1;
          st_phase = PH_RUN;
        end
      end
      PH_RUN: begin
        // A high switch defers the shutdown step to the next pass.
        if (b.dual_switch || b.single_switch) begin
          st_phase = PH_SHUTDOWN;
        end else if (!b.engine_permit) begin
          st_phase = PH_ENGCUT;
        end else if (st_await) begin
          if (b.evaporator_temp >= cfg_cut_in) begin
            st_await = 1'b0;
            st_clutch = 1'b1;
          end
        end else if (b.evaporator_temp <= cfg_cut_out) begin
          st_await = 1'b1;
          st_clutch = 1'b0;
        end
      end
      PH_ENGCUT: begin
        st_clutch = 1'b0;
        st_timer = b.now_ms;
        st_phase = PH_WAIT;
      end
      default: begin
      end
    endcase
    r.clutch_on = st_clutch;
    r.idle_up = st_idle_up;
    r.fan_request = st_fan;
    r.compressor_active = st_active;
    r.report_compressor = rep_comp;
    r.report_fan = rep_fan;
    r.phase = st_phase;
    return r;
  endfunction

  function automatic int draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 18);
  endfunction

  // Random pass: the clock mostly creeps forward so the wait phase ends
  // after a few beats, with an occasional jump anywhere in the 32-bit range.
  function automatic item_t make_beat();
    item_t b;
    int    pick;
    int    t;
    pick = $urandom_range(0, 99);
    if (pick < 70) sim_now += $urandom_range(0, cfg_delay / 4 + 2);
    else if (pick < 90) sim_now += $urandom_range(0, 2 * cfg_delay + 5);
    else if (pick >= 96) sim_now = $urandom();
    b.now_ms = sim_now;

    pick = $urandom_range(0, 99);
    b.kind = KIND_NONE;
    if (st_phase == PH_IDLE) begin
      if (pick < 35) b.kind = KIND_START;
      else if (pick < 37) b.kind = KIND_STOP;
      else if (pick < 39) b.kind = KIND_UNUSED;
    end else begin
      if (pick < 2) b.kind = KIND_START;
      else if (pick < 4) b.kind = KIND_STOP;
      else if (pick < 5) b.kind = KIND_UNUSED;
    end

    b.single_switch = ($urandom_range(0, 99) < 5);
    b.dual_switch = ($urandom_range(0, 99) < 5);
    b.engine_permit = ($urandom_range(0, 99) >= 6);

    // Temperatures cluster at the thresholds and the range ends.
    pick = $urandom_range(0, 9);
    if (pick == 0) t = int'(TEMP_MIN);
    else if (pick == 1) t = int'(TEMP_MAX);
    else if (pick < 6) t = int'(cfg_cut_in) + int'($urandom_range(0, 4)) - 2;
    else if (pick < 8) t = int'(cfg_cut_out) + int'($urandom_range(0, 4)) - 2;
    else t = $urandom();
    b.evaporator_temp = temp_t'(t);
    return b;
  endfunction

  // Present one beat, wait for it to be taken and record its result.
  task automatic send_beat(input item_t b, input logic fixed, input result_t want);
    int      gap;
    result_t r;
    gap = draw_wait(in_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= b.kind;
    in_now_ms <= b.now_ms;
    in_single_switch <= b.single_switch;
    in_dual_switch <= b.dual_switch;
    in_engine_permit <= b.engine_permit;
    in_evaporator_temp <= b.evaporator_temp;
    do @(posedge clk); while (in_stall);
    r = run_control_pass(b);
    awaited_drive.push_back(fixed ? want : r);
    sent_beats++;
    if (sent_beats % 40 == 0) in_calm = ($urandom_range(0, 3) == 0);
  endtask

  task automatic run_random(input int count);
    repeat (count) send_beat(make_beat(), 1'b0, '0);
  endtask

  // Drain the pipeline before touching the configuration.
  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_drive.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [DELAY_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_START_DELAY: cfg_delay = data;
      CFG_CUT_IN:      cfg_cut_in = data[TEMP_W-1:0];
      CFG_CUT_OUT:     cfg_cut_out = data[TEMP_W-1:0];
      default: begin
      end
    endcase
  endtask

  // Upper data bits of the temperature writes are noise the block must drop.
  task automatic cfg_program(input logic [DELAY_W-1:0] delay, input temp_t cut_in,
                             input temp_t cut_out);
    cfg_write(CFG_START_DELAY, delay);
    cfg_write(CFG_CUT_IN, {8'($urandom()), cut_in});
    cfg_write(CFG_CUT_OUT, {8'($urandom()), cut_out});
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [2:0] want,
                             input logic [2:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  // Result side stall pattern, one draw per beat.
  initial begin : result_sink
    int hold;
    int taken;
    taken = 0;
    wait (rst_n === 1'b1);
    forever begin
      hold = draw_wait(out_calm);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
      if (taken % 40 == 0) out_calm = ($urandom_range(0, 3) == 0);
    end
  end

  // Compare every accepted result beat with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_drive.size() == 0) begin
        $error("result beat with no prediction waiting");
        fails++;
      end else begin
        head_drive = awaited_drive.pop_front();
        check_field("clutch_on", 3'(head_drive.clutch_on), 3'(out_clutch_on));
        check_field("idle_up", 3'(head_drive.idle_up), 3'(out_idle_up));
        check_field("fan_request", 3'(head_drive.fan_request), 3'(out_fan_request));
        check_field("compressor_active", 3'(head_drive.compressor_active),
                    3'(out_compressor_active));
        check_field("report_compressor", 3'(head_drive.report_compressor),
                    3'(out_report_compressor));
        check_field("report_fan", 3'(head_drive.report_fan), 3'(out_report_fan));
        check_field("phase", head_drive.phase, out_phase);
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings first, through the hand-picked passes.
    for (int i = 0; i < ROWS; i++) begin
      send_beat(directed_rows[i].beat, directed_rows[i].fixed, directed_rows[i].want);
    end

    // Extreme and overlapping thresholds, then ordinary and random ones.
    settle();
    cfg_program(16'd0, TEMP_MAX, TEMP_MIN);
    run_random(200);
    settle();
    cfg_program(16'hFFFF, TEMP_MIN, TEMP_MAX);
    run_random(200);
    settle();
    cfg_program(16'd10, 8'sd5, 8'sd2);
    run_random(200);
    settle();
    cfg_program(16'($urandom_range(0, 300)), temp_t'($urandom()), temp_t'($urandom()));
    run_random(200);
    settle();

    if (fails == 0 && awaited_drive.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #1_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
